>>> src/frqcd_pkg.sv
// ----------------------------------------------------------------------------
// frqcd_pkg
// Shared widths, codes and structs of the ready-queue CPU dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package frqcd_pkg;

  localparam int MAX_CPUS      = 16;
  localparam int MAX_PROCESSES = 64;

  localparam int CPU_W   = $clog2(MAX_CPUS);
  localparam int PID_W   = $clog2(MAX_PROCESSES);
  localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
  localparam int OP_W    = 3;
  localparam int SLICE_W = 8;
  localparam int STATE_W = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-3:0] REG_SLICE = '0;

  localparam logic [STATE_W-1:0] ST_READY      = 2'd0;
  localparam logic [STATE_W-1:0] ST_RUNNING    = 2'd1;
  localparam logic [STATE_W-1:0] ST_WAITING    = 2'd2;
  localparam logic [STATE_W-1:0] ST_TERMINATED = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_IDLE      = 3'd0,
    OP_PREEMPT   = 3'd1,
    OP_YIELD     = 3'd2,
    OP_TERMINATE = 3'd3,
    OP_WAKE      = 3'd4
  } op_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [PID_W-1:0] id;
  } ring_req_t;

  typedef struct packed {
    logic             empty;
    logic [CNT_W-1:0] count;
    logic [PID_W-1:0] pop_data;
  } ring_stat_t;

  typedef struct packed {
    logic             run_wr;
    logic [CPU_W-1:0] run_cpu;
    logic             run_valid;
    logic [PID_W-1:0] run_id;
    logic             mask_wr;
    logic [CPU_W-1:0] mask_idx;
    logic             mask_bit;
  } tbl_upd_t;

  typedef struct packed {
    logic             run_valid;
    logic [PID_W-1:0] run_id;
    logic             any_wait;
    logic [CPU_W-1:0] low_wait;
  } tbl_stat_t;

  typedef struct packed {
    logic [CPU_W-1:0]   target_cpu;
    logic               has_process;
    logic [PID_W-1:0]   dispatched_pid;
    logic [SLICE_W-1:0] granted_slice;
    logic               released_valid;
    logic [PID_W-1:0]   released_process;
    logic [STATE_W-1:0] released_state;
  } res_t;

endpackage

`default_nettype wire

>>> src/frqcd_if.sv
// ----------------------------------------------------------------------------
// frqcd interfaces
// Event request channel and dispatch result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface frqcd_evt_if;
  logic                           valid;
  logic                           ready;
  logic [frqcd_pkg::OP_W-1:0]     op;
  logic [frqcd_pkg::CPU_W-1:0]    cpu_index;
  logic [frqcd_pkg::PID_W-1:0]    woken_process;

  modport source (output valid, op, cpu_index, woken_process, input ready);
  modport sink   (input valid, op, cpu_index, woken_process, output ready);
endinterface

interface frqcd_dsp_if;
  logic                           valid;
  logic                           ready;
  logic [frqcd_pkg::CPU_W-1:0]    target_cpu;
  logic                           has_process;
  logic [frqcd_pkg::PID_W-1:0]    dispatched_pid;
  logic [frqcd_pkg::SLICE_W-1:0]  granted_slice;
  logic                           released_valid;
  logic [frqcd_pkg::PID_W-1:0]    released_process;
  logic [frqcd_pkg::STATE_W-1:0]  released_state;

  modport source (output valid, target_cpu, has_process, dispatched_pid, granted_slice,
                  released_valid, released_process, released_state, input ready);
  modport sink   (input valid, target_cpu, has_process, dispatched_pid, granted_slice,
                  released_valid, released_process, released_state, output ready);
endinterface

`default_nettype wire

>>> src/frqcd_cfg.sv
// ----------------------------------------------------------------------------
// frqcd_cfg
// APB register port holding the time slice handed out with each dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module frqcd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frqcd_pkg::PADDR_W-1:0]   paddr,
  input  logic [frqcd_pkg::PDATA_W-1:0]   pwdata,
  output logic [frqcd_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output logic [frqcd_pkg::SLICE_W-1:0]   slice_length
);

  logic hit;

  assign hit    = (paddr[frqcd_pkg::PADDR_W-1:2] == frqcd_pkg::REG_SLICE);
  assign pready = 1'b1;
  assign prdata = hit ? frqcd_pkg::PDATA_W'(slice_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= '0;
    end else if (psel && penable && pwrite && pready && hit) begin
      slice_length <= pwdata[frqcd_pkg::SLICE_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/frqcd_ring.sv
// ----------------------------------------------------------------------------
// frqcd_ring
// FIFO ring of ready process ids; registered read of the next head with
// write forwarding, so the head entry is at hand every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frqcd_ring (
  input  logic                   clk,
  input  logic                   rst,
  input  frqcd_pkg::ring_req_t   req,
  output frqcd_pkg::ring_stat_t  stat
);

  localparam int PID_W = frqcd_pkg::PID_W;
  localparam int CNT_W = frqcd_pkg::CNT_W;
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(frqcd_pkg::MAX_PROCESSES);

  logic [PID_W-1:0] mem [frqcd_pkg::MAX_PROCESSES];
  logic [PID_W-1:0] head;
  logic [PID_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] wr_sum;
  logic [PID_W-1:0] wr_addr;
  logic             push_ok;
  logic [PID_W-1:0] rd_q;
  logic             fwd;
  logic [PID_W-1:0] fwd_q;

  assign push_ok = req.push && (count != DEPTH);
  assign wr_sum  = CNT_W'(head) + count;
  assign wr_addr = (wr_sum >= DEPTH) ? PID_W'(wr_sum - DEPTH) : PID_W'(wr_sum);

  always_comb begin
    head_next = head;
    if (req.pop) begin
      head_next = (CNT_W'(head) == DEPTH - CNT_W'(1)) ? '0 : head + PID_W'(1);
    end
    count_next = count + CNT_W'(push_ok) - CNT_W'(req.pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_addr] <= req.id;
    end
    rd_q  <= mem[head_next];
    fwd   <= push_ok && (wr_addr == head_next);
    fwd_q <= req.id;
  end

  // empty ring: a pop in the same cycle takes the id being pushed
  assign stat.empty    = (count == '0);
  assign stat.count    = count;
  assign stat.pop_data = stat.empty ? req.id : (fwd ? fwd_q : rd_q);

endmodule

`default_nettype wire

>>> src/frqcd_cpu_tbl.sv
// ----------------------------------------------------------------------------
// frqcd_cpu_tbl
// Running process of each CPU and the mask of idle CPUs waiting for work,
// with a lowest-index pick over the mask.
// ----------------------------------------------------------------------------
`default_nettype none

module frqcd_cpu_tbl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [frqcd_pkg::CPU_W-1:0]   cpu_sel,
  input  frqcd_pkg::tbl_upd_t           upd,
  output frqcd_pkg::tbl_stat_t          stat
);

  localparam int NCPU  = frqcd_pkg::MAX_CPUS;
  localparam int CPU_W = frqcd_pkg::CPU_W;

  logic                       run_valid [NCPU];
  logic [frqcd_pkg::PID_W-1:0] run_id   [NCPU];
  logic [NCPU-1:0]            wait_mask;
  logic [CPU_W-1:0]           low;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCPU; i++) begin
        run_valid[i] <= 1'b0;
      end
      wait_mask <= '0;
    end else begin
      if (upd.run_wr) begin
        run_valid[upd.run_cpu] <= upd.run_valid;
      end
      if (upd.mask_wr) begin
        wait_mask[upd.mask_idx] <= upd.mask_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.run_wr) begin
      run_id[upd.run_cpu] <= upd.run_id;
    end
  end

  always_comb begin
    low = '0;
    for (int i = NCPU - 1; i >= 0; i--) begin
      if (wait_mask[i]) begin
        low = CPU_W'(i);
      end
    end
  end

  assign stat.run_valid = run_valid[cpu_sel];
  assign stat.run_id    = run_id[cpu_sel];
  assign stat.any_wait  = |wait_mask;
  assign stat.low_wait  = low;

endmodule

`default_nettype wire

>>> src/fifo_ready_queue_cpu_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// fifo_ready_queue_cpu_dispatcher_unit
// Round-robin ready-queue scheduler: takes CPU events and wake-ups, keeps a
// FIFO of ready process ids and issues context-switch dispatches.
//
//   channel   dir  handshake        payload
//   sched     in   valid / ready    op, cpu_index, woken_process
//   dispatch  out  valid / ready    target_cpu .. released_state
//   apb       in   psel / penable   slice_length at byte address 0
//
// one event per cycle while no result is held: an input register, decode
// against the ring and CPU table, then the result register
// the ring head is read from a registered RAM port with write forwarding
// synchronous reset clears the ring pointers, CPU table valid flags and waiting mask
// a held result stalls the event stage, and a full input register then
// holds off the next request
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_ready_queue_cpu_dispatcher_unit (
  input  logic                           clk,
  input  logic                           rst,
  frqcd_evt_if.sink                      sched,
  frqcd_dsp_if.source                    dispatch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [frqcd_pkg::PADDR_W-1:0]  paddr,
  input  logic [frqcd_pkg::PDATA_W-1:0]  pwdata,
  output logic [frqcd_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);

  localparam int CNT_W = frqcd_pkg::CNT_W;

  logic [frqcd_pkg::SLICE_W-1:0] slice_length;

  logic                          s1_valid;
  frqcd_pkg::op_t                s1_op;
  logic [frqcd_pkg::CPU_W-1:0]   s1_cpu;
  logic [frqcd_pkg::PID_W-1:0]   s1_pid;

  logic                          fire;
  logic                          has_result;
  logic                          avail;
  logic                          res_valid;
  frqcd_pkg::res_t               res;
  frqcd_pkg::res_t               res_next;

  frqcd_pkg::ring_req_t          ring_req;
  frqcd_pkg::ring_stat_t         ring_st;
  frqcd_pkg::tbl_upd_t           tbl_upd;
  frqcd_pkg::tbl_stat_t          tbl_st;

  frqcd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .slice_length (slice_length)
  );

  frqcd_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .req  (ring_req),
    .stat (ring_st)
  );

  frqcd_cpu_tbl u_tbl (
    .clk     (clk),
    .rst     (rst),
    .cpu_sel (s1_cpu),
    .upd     (tbl_upd),
    .stat    (tbl_st)
  );

  assign fire        = s1_valid && (!res_valid || dispatch.ready);
  assign sched.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sched.ready) begin
      s1_valid <= sched.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sched.valid && sched.ready) begin
      s1_op  <= frqcd_pkg::op_t'(sched.op);
      s1_cpu <= sched.cpu_index;
      s1_pid <= sched.woken_process;
    end
  end

  always_comb begin
    ring_req   = '0;
    tbl_upd    = '0;
    res_next   = '0;
    has_result = 1'b0;
    avail      = 1'b0;
    case (s1_op)
      frqcd_pkg::OP_WAKE: begin
        if (tbl_st.any_wait) begin
          tbl_upd.run_wr          = 1'b1;
          tbl_upd.run_cpu         = tbl_st.low_wait;
          tbl_upd.run_valid       = 1'b1;
          tbl_upd.run_id          = s1_pid;
          tbl_upd.mask_wr         = 1'b1;
          tbl_upd.mask_idx        = tbl_st.low_wait;
          tbl_upd.mask_bit        = 1'b0;
          has_result              = 1'b1;
          res_next.target_cpu     = tbl_st.low_wait;
          res_next.has_process    = 1'b1;
          res_next.dispatched_pid = s1_pid;
          res_next.granted_slice  = slice_length;
        end else begin
          ring_req.push = 1'b1;
          ring_req.id   = s1_pid;
        end
      end
      frqcd_pkg::OP_IDLE: begin
        tbl_upd.mask_wr  = 1'b1;
        tbl_upd.mask_idx = s1_cpu;
        tbl_upd.mask_bit = ring_st.empty;
        if (!ring_st.empty) begin
          ring_req.pop            = 1'b1;
          tbl_upd.run_wr          = 1'b1;
          tbl_upd.run_cpu         = s1_cpu;
          tbl_upd.run_valid       = 1'b1;
          tbl_upd.run_id          = ring_st.pop_data;
          has_result              = 1'b1;
          res_next.target_cpu     = s1_cpu;
          res_next.has_process    = 1'b1;
          res_next.dispatched_pid = ring_st.pop_data;
          res_next.granted_slice  = slice_length;
        end
      end
      frqcd_pkg::OP_PREEMPT, frqcd_pkg::OP_YIELD, frqcd_pkg::OP_TERMINATE: begin
        tbl_upd.mask_wr  = 1'b1;
        tbl_upd.mask_idx = s1_cpu;
        tbl_upd.mask_bit = 1'b0;
        // preempted process rejoins the tail before the head is taken
        ring_req.push    = tbl_st.run_valid && (s1_op == frqcd_pkg::OP_PREEMPT);
        ring_req.id      = tbl_st.run_id;
        avail            = !ring_st.empty || ring_req.push;
        ring_req.pop     = avail;
        tbl_upd.run_wr   = 1'b1;
        tbl_upd.run_cpu  = s1_cpu;
        tbl_upd.run_valid = avail;
        tbl_upd.run_id   = ring_st.pop_data;
        has_result       = 1'b1;
        res_next.target_cpu     = s1_cpu;
        res_next.has_process    = avail;
        res_next.dispatched_pid = avail ? ring_st.pop_data : '0;
        res_next.granted_slice  = avail ? slice_length : '0;
        res_next.released_valid = tbl_st.run_valid;
        if (tbl_st.run_valid) begin
          res_next.released_process = tbl_st.run_id;
          case (s1_op)
            frqcd_pkg::OP_PREEMPT: res_next.released_state = frqcd_pkg::ST_READY;
            frqcd_pkg::OP_YIELD:   res_next.released_state = frqcd_pkg::ST_WAITING;
            default:               res_next.released_state = frqcd_pkg::ST_TERMINATED;
          endcase
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
    if (!fire) begin
      ring_req.push   = 1'b0;
      ring_req.pop    = 1'b0;
      tbl_upd.run_wr  = 1'b0;
      tbl_upd.mask_wr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= has_result;
    end else if (dispatch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign dispatch.valid            = res_valid;
  assign dispatch.target_cpu       = res.target_cpu;
  assign dispatch.has_process      = res.has_process;
  assign dispatch.dispatched_pid   = res.dispatched_pid;
  assign dispatch.granted_slice    = res.granted_slice;
  assign dispatch.released_valid   = res.released_valid;
  assign dispatch.released_process = res.released_process;
  assign dispatch.released_state   = res.released_state;

`ifndef SYNTHESIS
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    ring_st.count <= CNT_W'(frqcd_pkg::MAX_PROCESSES))
    else $error("ring count above depth");

  a_ring_step: assert property (@(posedge clk) disable iff (rst)
    (ring_st.count == $past(ring_st.count)) ||
    (ring_st.count == $past(ring_st.count) + CNT_W'(1)) ||
    (ring_st.count == $past(ring_st.count) - CNT_W'(1)))
    else $error("ring count moved by more than one");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    fire && has_result |=> res_valid)
    else $error("processed event lost its result");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_process |->
      (res.dispatched_pid == '0) && (res.granted_slice == '0))
    else $error("idle dispatch carries process fields");
`endif

endmodule

`default_nettype wire
